>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Every check is clocked on the rising
// edge and is switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define KR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define KR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/kr_pkg.sv
`default_nettype none

package kr_pkg;

  localparam int ENTRIES = 16;
  localparam int COURSES = 3;
  localparam int PACKED  = 3;
  localparam int MAX_RES = 16;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam int OP_W     = 2;
  localparam int KEY_W    = 8;
  localparam int YEAR_W   = 8;
  localparam int PACK_W   = 24;
  localparam int USED_W   = 5;
  localparam int GRADE_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Width of an input byte list once extended to cover every course.
  localparam int SPAN = 8 * ((COURSES > PACKED) ? COURSES : PACKED);

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_DEL    = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_LIST   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_GRADE = 2'd0,
    REG_MAX_GRADE = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [KEY_W-1:0]              key;
    logic [YEAR_W-1:0]             year;
    logic [COURSES-1:0][7:0]       subj;
    logic [COURSES-1:0][GRADE_W-1:0] grade;
  } rec_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    rec_t             wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic              ok;
    logic [YEAR_W-1:0] found_year;
    logic [PACK_W-1:0] found_subjects;
    logic [PACK_W-1:0] found_grades;
    logic [KEY_W-1:0]  listed_id;
    logic              id_valid;
    logic              last;
    logic [USED_W-1:0] used_count;
    logic              full_res;
  } res_t;

endpackage

`default_nettype wire

>>> hw/rtl/kr_in_if.sv
`default_nettype none

interface kr_in_if;
  import kr_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [KEY_W-1:0]  key_id;
  logic [YEAR_W-1:0] new_year;
  logic [PACK_W-1:0] new_subjects;
  logic [PACK_W-1:0] new_grades;

  modport source (output valid, op, key_id, new_year, new_subjects, new_grades,
                  input ready);
  modport sink (input valid, op, key_id, new_year, new_subjects, new_grades,
                output ready);
endinterface

`default_nettype wire

>>> hw/rtl/kr_out_if.sv
`default_nettype none

interface kr_out_if;
  import kr_pkg::*;

  logic              valid;
  logic              ready;
  logic              ok;
  logic [YEAR_W-1:0] found_year;
  logic [PACK_W-1:0] found_subjects;
  logic [PACK_W-1:0] found_grades;
  logic [KEY_W-1:0]  listed_id;
  logic              id_valid;
  logic              last;
  logic [USED_W-1:0] used_count;
  logic              full_res;

  modport source (output valid, ok, found_year, found_subjects, found_grades,
                  listed_id, id_valid, last, used_count, full_res,
                  input ready);
  modport sink (input valid, ok, found_year, found_subjects, found_grades,
                listed_id, id_valid, last, used_count, full_res,
                output ready);
endinterface

`default_nettype wire

>>> hw/rtl/keyed_record_table.sv
// Channel   Dir  Beat carries                                       Accepted when
// in_ch     in   op, key_id, new_year, new_subjects, new_grades       valid && ready
// out_ch    out  ok, found_*, listed_id, id_valid, last, used_count,  valid && ready
//                full_res
// cfg       in   cfg_index, cfg_data                                  cfg_we
//
// One command at a time; a record is moved or probed through the table store,
// which has one read and one write port. Add shifts each held record up a slot
// by a read then a write and puts the new one in slot 0 (refused when full);
// lookup probes from slot 0 to a hit; delete probes too, then shifts later
// records down; list reads keys newest first. Reset is synchronous and empties
// the table at once. The result register lets the next command be taken while a
// beat waits; list and final beats stall on out_ch.ready low with a beat held.
`default_nettype none

module keyed_record_table (
  input  wire logic                           clk,
  input  wire logic                           rst,
  kr_in_if.sink                               in_ch,
  kr_out_if.source                            out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [kr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [kr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import kr_pkg::*;

  logic [GRADE_W-1:0] grade_lo;
  logic [GRADE_W-1:0] grade_hi;
  mem_req_t           mem_req;
  rec_t               mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      grade_lo <= GRADE_W'(0);
      grade_hi <= GRADE_W'(100);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MIN_GRADE: grade_lo <= cfg_data;
        REG_MAX_GRADE: grade_hi <= cfg_data;
        default: ;
      endcase
    end
  end

  kr_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  kr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .grade_lo  (grade_lo),
    .grade_hi  (grade_hi),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

endmodule

`default_nettype wire

>>> hw/rtl/kr_store.sv
`default_nettype none

module kr_store (
  input  wire logic            clk,
  input  wire kr_pkg::mem_req_t req,
  output kr_pkg::rec_t         rdata
);
  import kr_pkg::*;

  rec_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/kr_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

module kr_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  kr_in_if.sink                            in_ch,
  kr_out_if.source                         out_ch,
  input  wire logic [kr_pkg::GRADE_W-1:0]  grade_lo,
  input  wire logic [kr_pkg::GRADE_W-1:0]  grade_hi,
  output kr_pkg::mem_req_t                 mem_req,
  input  wire kr_pkg::rec_t                mem_rdata
);
  import kr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_WR,
    S_ADD_PUT,
    S_FIND_RD,
    S_FIND_CMP,
    S_DEL_RD,
    S_DEL_WR,
    S_LIST_RD,
    S_LIST_OUT,
    S_DONE
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] occ;
  logic [CNT_W-1:0] ptr;
  logic [CNT_W-1:0] ptr_p1;
  logic [CNT_W-1:0] ptr_m1;
  op_t              cmd_op;
  logic [KEY_W-1:0] cmd_key;
  rec_t             cmd_rec;
  rec_t             hit_rec;
  logic             r_ok;
  res_t             res;
  logic             res_valid;
  logic             res_load;
  logic             out_free;
  logic             key_hit;
  logic             list_last;
  rec_t             new_rec;
  logic [SPAN-1:0]  subj_ext;
  logic [SPAN-1:0]  grd_ext;

  function automatic logic [GRADE_W-1:0] clamp(input logic [GRADE_W-1:0] g,
                                               input logic [GRADE_W-1:0] lo,
                                               input logic [GRADE_W-1:0] hi);
    logic [GRADE_W-1:0] v;
    v = (g < lo) ? lo : g;
    v = (v > hi) ? hi : v;
    return v;
  endfunction

  always_comb begin
    subj_ext     = SPAN'(in_ch.new_subjects);
    grd_ext      = SPAN'(in_ch.new_grades);
    new_rec.key  = in_ch.key_id;
    new_rec.year = in_ch.new_year;
    new_rec.subj = subj_ext[8*COURSES-1:0];
    for (int c = 0; c < COURSES; c++) begin
      new_rec.grade[c] = clamp(grd_ext[8*c +: 8], grade_lo, grade_hi);
    end
  end

  assign ptr_p1    = ptr + 1'b1;
  assign ptr_m1    = ptr - 1'b1;
  assign out_free  = !res_valid || out_ch.ready;
  assign res_load  = ((state == S_LIST_OUT) || (state == S_DONE)) && out_free;
  // The one key comparator, reused on every probed slot.
  assign key_hit   = (mem_rdata.key == cmd_key);
  assign list_last = (ptr_p1 == occ) || (32'(ptr_p1) == MAX_RES);

  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.waddr = ptr[IDX_W-1:0];
    mem_req.wdata = mem_rdata;
    mem_req.raddr = ptr[IDX_W-1:0];
    case (state)
      S_ADD_RD:  mem_req.raddr = ptr_m1[IDX_W-1:0];
      S_ADD_WR:  mem_req.we    = 1'b1;
      S_ADD_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = '0;
        mem_req.wdata = cmd_rec;
      end
      S_DEL_RD:  mem_req.raddr = ptr_p1[IDX_W-1:0];
      S_DEL_WR:  mem_req.we    = 1'b1;
      default:   mem_req.we    = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (out_ch.ready && !res_load) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            cmd_op  <= op_t'(in_ch.op);
            cmd_key <= in_ch.key_id;
            cmd_rec <= new_rec;
            r_ok    <= 1'b0;
            case (op_t'(in_ch.op))
              OP_ADD: begin
                if (32'(occ) >= ENTRIES) begin
                  ptr   <= '0;
                  state <= S_DONE;
                end else if (occ == '0) begin
                  ptr   <= '0;
                  state <= S_ADD_PUT;
                end else begin
                  ptr   <= occ;
                  state <= S_ADD_RD;
                end
              end
              OP_DEL, OP_LOOKUP: begin
                ptr   <= '0;
                state <= (occ == '0) ? S_DONE : S_FIND_RD;
              end
              default: begin
                ptr   <= '0;
                state <= (occ == '0) ? S_DONE : S_LIST_RD;
              end
            endcase
          end
        end
        S_ADD_RD: state <= S_ADD_WR;
        S_ADD_WR: begin
          ptr   <= ptr_m1;
          state <= (ptr == CNT_W'(1)) ? S_ADD_PUT : S_ADD_RD;
        end
        S_ADD_PUT: begin
          occ   <= occ + 1'b1;
          r_ok  <= 1'b1;
          state <= S_DONE;
        end
        S_FIND_RD: state <= S_FIND_CMP;
        S_FIND_CMP: begin
          if (key_hit) begin
            r_ok    <= 1'b1;
            hit_rec <= mem_rdata;
            if (cmd_op == OP_LOOKUP) begin
              state <= S_DONE;
            end else if (ptr_p1 < occ) begin
              state <= S_DEL_RD;
            end else begin
              occ   <= occ - 1'b1;
              state <= S_DONE;
            end
          end else if (ptr_p1 == occ) begin
            state <= S_DONE;
          end else begin
            ptr   <= ptr_p1;
            state <= S_FIND_RD;
          end
        end
        S_DEL_RD: state <= S_DEL_WR;
        S_DEL_WR: begin
          ptr <= ptr_p1;
          if ((ptr_p1 + 1'b1) < occ) begin
            state <= S_DEL_RD;
          end else begin
            occ   <= occ - 1'b1;
            state <= S_DONE;
          end
        end
        S_LIST_RD: state <= S_LIST_OUT;
        S_LIST_OUT: begin
          // The read address stays on ptr, so the key holds while we wait.
          if (out_free) begin
            res_valid          <= 1'b1;
            res.ok             <= 1'b0;
            res.found_year     <= '0;
            res.found_subjects <= '0;
            res.found_grades   <= '0;
            res.listed_id      <= mem_rdata.key;
            res.id_valid       <= 1'b1;
            res.last           <= list_last;
            res.used_count     <= USED_W'(occ);
            res.full_res       <= (32'(occ) == ENTRIES);
            if (list_last) begin
              state <= S_IDLE;
            end else begin
              ptr   <= ptr_p1;
              state <= S_LIST_RD;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            res_valid     <= 1'b1;
            res.ok        <= r_ok;
            if (r_ok && cmd_op == OP_LOOKUP) begin
              res.found_year     <= hit_rec.year;
              res.found_subjects <= PACK_W'(hit_rec.subj);
              res.found_grades   <= PACK_W'(hit_rec.grade);
            end else begin
              res.found_year     <= '0;
              res.found_subjects <= '0;
              res.found_grades   <= '0;
            end
            res.listed_id  <= '0;
            res.id_valid   <= 1'b0;
            res.last       <= 1'b1;
            res.used_count <= USED_W'(occ);
            res.full_res   <= (32'(occ) == ENTRIES);
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready           = (state == S_IDLE);
  assign out_ch.valid          = res_valid;
  assign out_ch.ok             = res.ok;
  assign out_ch.found_year     = res.found_year;
  assign out_ch.found_subjects = res.found_subjects;
  assign out_ch.found_grades   = res.found_grades;
  assign out_ch.listed_id      = res.listed_id;
  assign out_ch.id_valid       = res.id_valid;
  assign out_ch.last           = res.last;
  assign out_ch.used_count     = res.used_count;
  assign out_ch.full_res       = res.full_res;

  `KR_ASSERT_IMP(a_occ_bound, clk, rst, 1'b1, 32'(occ) <= ENTRIES, "occupancy above table size")
  `KR_ASSERT_IMP(a_occ_step, clk, rst, !$past(rst) && occ != $past(occ), occ == $past(occ) + 1'b1 || occ + 1'b1 == $past(occ), "occupancy moved by more than one")
  `KR_ASSERT_IMP(a_res_kind, clk, rst, res_valid, !(res.ok && res.id_valid), "list beat flagged as ok")
  `KR_ASSERT_NXT(a_done_beat, clk, rst, state == S_DONE && out_free, res_valid && res.last, "final beat not loaded")
  `KR_ASSERT_IMP(a_idle_quiet, clk, rst, state == S_IDLE, !mem_req.we, "table written while idle")

endmodule

`default_nettype wire

>>> sim/record_table_checker.sv
module record_table_checker
  import kr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  kr_in_if                      in_ch,
  kr_out_if                     out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the table, newest record in slot 0.
  logic [KEY_W-1:0]                rec_key   [ENTRIES];
  logic [YEAR_W-1:0]               rec_year  [ENTRIES];
  logic [COURSES-1:0][7:0]         rec_subj  [ENTRIES];
  logic [COURSES-1:0][GRADE_W-1:0] rec_grade [ENTRIES];
  int                              held;
  logic [GRADE_W-1:0]              lo_grade;
  logic [GRADE_W-1:0]              hi_grade;
  res_t                            expected_results[$];

  initial begin
    fail_count   = 0;
    results_owed = 0;
  end

  // A beat carrying nothing but the table status; fields are filled in later.
  function automatic res_t status_beat();
    res_t r;
    r            = '0;
    r.last       = 1'b1;
    r.used_count = USED_W'(held);
    r.full_res   = (held == ENTRIES);
    return r;
  endfunction

  // Raising to the minimum comes first, so the maximum wins when they cross.
  function automatic logic [GRADE_W-1:0] bound_grade(logic [7:0] g);
    logic [GRADE_W-1:0] v;
    v = g;
    if (v < lo_grade) v = lo_grade;
    if (v > hi_grade) v = hi_grade;
    return v;
  endfunction

  function automatic int newest_match(logic [KEY_W-1:0] key);
    for (int i = 0; i < held && i < ENTRIES; i++) begin
      if (rec_key[i] == key) return i;
    end
    return -1;
  endfunction

  task automatic apply_command(op_t op, logic [KEY_W-1:0] key, logic [YEAR_W-1:0] year,
                               logic [PACK_W-1:0] subj, logic [PACK_W-1:0] grades);
    res_t r;
    int   idx;
    int   n;
    case (op)
      OP_ADD: begin
        r = status_beat();
        if (held < ENTRIES) begin
          for (int i = held; i > 0; i--) begin
            rec_key[i]   = rec_key[i-1];
            rec_year[i]  = rec_year[i-1];
            rec_subj[i]  = rec_subj[i-1];
            rec_grade[i] = rec_grade[i-1];
          end
          rec_key[0]  = key;
          rec_year[0] = year;
          for (int c = 0; c < COURSES; c++) begin
            rec_subj[0][c]  = (c < PACKED) ? subj[8*c +: 8] : 8'd0;
            rec_grade[0][c] = bound_grade((c < PACKED) ? grades[8*c +: 8] : 8'd0);
          end
          held++;
          r    = status_beat();
          r.ok = 1'b1;
        end
        expected_results.push_back(r);
      end
      OP_DEL: begin
        idx = newest_match(key);
        if (idx >= 0) begin
          for (int i = idx; i + 1 < held; i++) begin
            rec_key[i]   = rec_key[i+1];
            rec_year[i]  = rec_year[i+1];
            rec_subj[i]  = rec_subj[i+1];
            rec_grade[i] = rec_grade[i+1];
          end
          held--;
        end
        r    = status_beat();
        r.ok = (idx >= 0);
        expected_results.push_back(r);
      end
      OP_LOOKUP: begin
        idx = newest_match(key);
        r   = status_beat();
        if (idx >= 0) begin
          r.ok         = 1'b1;
          r.found_year = rec_year[idx];
          for (int c = 0; c < COURSES && c < PACKED; c++) begin
            r.found_subjects[8*c +: 8] = rec_subj[idx][c];
            r.found_grades[8*c +: 8]   = rec_grade[idx][c];
          end
        end
        expected_results.push_back(r);
      end
      default: begin
        n = (held > MAX_RES) ? MAX_RES : held;
        if (n == 0) begin
          expected_results.push_back(status_beat());
        end else begin
          for (int i = 0; i < n; i++) begin
            r           = status_beat();
            r.listed_id = rec_key[i];
            r.id_valid  = 1'b1;
            r.last      = (i == n - 1);
            expected_results.push_back(r);
          end
        end
      end
    endcase
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      held     = 0;
      lo_grade = 8'd0;
      hi_grade = 8'd100;
      expected_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat arrived with no command outstanding");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("ok",             want.ok,             out_ch.ok);
          check_field("found_year",     want.found_year,     out_ch.found_year);
          check_field("found_subjects", want.found_subjects, out_ch.found_subjects);
          check_field("found_grades",   want.found_grades,   out_ch.found_grades);
          check_field("listed_id",      want.listed_id,      out_ch.listed_id);
          check_field("id_valid",       want.id_valid,       out_ch.id_valid);
          check_field("last",           want.last,           out_ch.last);
          check_field("used_count",     want.used_count,     out_ch.used_count);
          check_field("full_res",       want.full_res,       out_ch.full_res);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        apply_command(op_t'(in_ch.op), in_ch.key_id, in_ch.new_year,
                      in_ch.new_subjects, in_ch.new_grades);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_GRADE: lo_grade = cfg_data;
          REG_MAX_GRADE: hi_grade = cfg_data;
          default: ;
        endcase
      end
    end
    results_owed = expected_results.size();
  end

endmodule

>>> sim/tb_top.sv
module tb_top;
  import kr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 42;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    results_owed;
  int                    gap_pct;
  int                    stall_pct;
  int                    quiet_cycles;

  kr_in_if  in_ch ();
  kr_out_if out_ch ();

  keyed_record_table dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  record_table_checker chk (
    .clk          (clk),
    .rst          (rst),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // Ends the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(op_t op, logic [KEY_W-1:0] key, logic [YEAR_W-1:0] year,
                           logic [PACK_W-1:0] subj, logic [PACK_W-1:0] grades);
    if ($urandom_range(99) < gap_pct) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.op           = op;
    in_ch.key_id       = key;
    in_ch.new_year     = year;
    in_ch.new_subjects = subj;
    in_ch.new_grades   = grades;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Lets every outstanding beat come out, then gives the block time to finish
  // any record shifting still under way.
  task automatic drain();
    in_ch.valid = 1'b0;
    wait (results_owed == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [7:0] min_setting [PHASES];
    logic [7:0] max_setting [PHASES];
    int         add_weight  [PHASES];
    int         pick;
    op_t        op;
    logic [7:0] key;

    min_setting = '{8'd0,   8'd200, 8'd255, 8'd0, 8'd0,   8'd40};
    max_setting = '{8'd255, 8'd50,  8'd255, 8'd0, 8'd100, 8'd90};
    add_weight  = '{60, 35, 70, 25, 50, 45};

    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = REG_MIN_GRADE;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.op           = OP_ADD;
    in_ch.key_id       = '0;
    in_ch.new_year     = '0;
    in_ch.new_subjects = '0;
    in_ch.new_grades   = '0;
    gap_pct            = 0;
    stall_pct          = 0;
    quiet_cycles       = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty table, absent keys, field extremes, a duplicate key, overfilling.
    send_item(OP_LIST,   8'h00, 8'h00, 24'h0, 24'h0);
    send_item(OP_LOOKUP, 8'h55, 8'h00, 24'h0, 24'h0);
    send_item(OP_DEL,    8'h55, 8'h00, 24'h0, 24'h0);
    send_item(OP_ADD,    8'h00, 8'h00, 24'h000000, 24'h000000);
    send_item(OP_ADD,    8'hFF, 8'hFF, 24'hFFFFFF, 24'hFFFFFF);
    send_item(OP_ADD,    8'hFF, 8'h5A, 24'hA5C33C, 24'h326401);
    send_item(OP_LOOKUP, 8'hFF, 8'h00, 24'h0, 24'h0);
    send_item(OP_DEL,    8'hFF, 8'h00, 24'h0, 24'h0);
    send_item(OP_LOOKUP, 8'hFF, 8'h00, 24'h0, 24'h0);
    send_item(OP_LIST,   8'h00, 8'h00, 24'h0, 24'h0);
    for (int i = 1; i <= 14; i++) begin
      send_item(OP_ADD, 8'(i), 8'($urandom), 24'($urandom), 24'($urandom));
    end
    send_item(OP_ADD,    8'hAA, 8'h01, 24'h010203, 24'h040506);
    send_item(OP_LIST,   8'h00, 8'h00, 24'h0, 24'h0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p == 4) begin
        write_reg(REG_MIN_GRADE, 8'($urandom));
        write_reg(REG_MAX_GRADE, 8'($urandom));
      end else begin
        write_reg(REG_MIN_GRADE, min_setting[p]);
        write_reg(REG_MAX_GRADE, max_setting[p]);
      end
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 48; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 48; end
        default: begin gap_pct = 22; stall_pct = 22; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < add_weight[p]) begin
          op = OP_ADD;
        end else begin
          pick = $urandom_range(9);
          op = (pick < 4) ? OP_DEL : (pick < 8) ? OP_LOOKUP : OP_LIST;
        end
        // A narrow key range keeps hits and duplicates frequent.
        key = ($urandom_range(99) < 75) ? 8'($urandom_range(15)) : 8'($urandom);
        send_item(op, key, 8'($urandom), 24'($urandom), 24'($urandom));
      end
    end

    drain();
    if (fail_count == 0 && results_owed == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
